// ----- src/ppd_pkg.sv -----
package ppd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned LIMIT_WIDTH     = 24;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 24'd10485760;

  localparam logic [3:0]  HDR_LAST_IDX  = 4'd15;
  localparam logic [15:0] HDR_BYTES     = 16'd16;
  localparam logic [31:0] CMD_HEARTBEAT = 32'd3;
  localparam logic [31:0] CMD_MESSAGE   = 32'd5;
  localparam logic [31:0] CMD_AUTH      = 32'd8;
  localparam logic [31:0] HB_PKT_LEN    = 32'd20;

  localparam logic [1:0] EV_MSG_BYTE = 2'd0;
  localparam logic [1:0] EV_AUDIENCE = 2'd1;
  localparam logic [1:0] EV_ERROR    = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_HDR_LEN = 2'd1;
  localparam logic [1:0] ERR_CMD     = 2'd2;
  localparam logic [1:0] ERR_LENGTH  = 2'd3;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [31:0] data;
    logic [1:0]  error_code;
    logic [31:0] sequence_res;
    logic        last;
    logic        empty_res;
  } ppd_result_t;

endpackage

// ----- src/ppd_front.sv -----
module ppd_front import ppd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_WIDTH-1:0] cfg_wr_data,
  input  logic                   accept,
  input  logic [7:0]             data_byte,
  input  logic                   start_of_stream,
  output logic                   push,
  output ppd_result_t            push_data
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_eff;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt, idx;
  logic [31:0]            pkt_len_r, pkt_len_nxt;
  logic [15:0]            hdr_len_r, hdr_len_nxt;
  logic [31:0]            cmd_r, cmd_nxt;
  logic [31:0]            seq_r, seq_nxt;
  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic                   is_msg_r, is_msg_nxt;
  logic                   is_hb4_r, is_hb4_nxt;
  logic [LIMIT_WIDTH-1:0] limit_r;
  logic [31:0]            pay_len;
  logic                   rem_last;

  assign pay_len  = pkt_len_r - 32'(HDR_BYTES);
  assign rem_last = (rem_r == COUNT_WIDTH'(1));

  always_comb begin
    phase_eff   = start_of_stream ? PH_HEADER : phase_r;
    idx         = start_of_stream ? 4'd0 : hdr_cnt_r;
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    pkt_len_nxt = pkt_len_r;
    hdr_len_nxt = hdr_len_r;
    cmd_nxt     = cmd_r;
    seq_nxt     = seq_r;
    rem_nxt     = rem_r;
    acc_nxt     = acc_r;
    is_msg_nxt  = is_msg_r;
    is_hb4_nxt  = is_hb4_r;
    push        = 1'b0;
    push_data   = '0;
    if (accept) begin
      phase_nxt   = phase_eff;
      hdr_cnt_nxt = idx;
      unique case (phase_eff)
        PH_HEADER: begin
          if (idx < 4'd4) begin
            pkt_len_nxt = {pkt_len_r[23:0], data_byte};
          end else if (idx < 4'd6) begin
            hdr_len_nxt = {hdr_len_r[7:0], data_byte};
          end else if (idx >= 4'd8 && idx < 4'd12) begin
            cmd_nxt = {cmd_r[23:0], data_byte};
          end else if (idx >= 4'd12) begin
            seq_nxt = {seq_r[23:0], data_byte};
          end
          if (idx != HDR_LAST_IDX) begin
            hdr_cnt_nxt = idx + 4'd1;
          end else begin
            // header complete: check in priority order
            hdr_cnt_nxt = 4'd0;
            push_data.event_res = EV_ERROR;
            push_data.last      = 1'b1;
            priority if (hdr_len_r != HDR_BYTES) begin
              push_data.error_code = ERR_HDR_LEN;
            end else if (cmd_r != CMD_HEARTBEAT && cmd_r != CMD_MESSAGE &&
                         cmd_r != CMD_AUTH) begin
              push_data.error_code = ERR_CMD;
            end else if (pkt_len_r < 32'(HDR_BYTES) ||
                         pay_len > {8'd0, limit_r} ||
                         (pay_len >> COUNT_WIDTH) != 32'd0) begin
              push_data.error_code = ERR_LENGTH;
            end else begin
              push_data.error_code = ERR_NONE;
            end
            if (push_data.error_code != ERR_NONE) begin
              phase_nxt = PH_DROP;
              push      = 1'b1;
            end else if (pay_len == 32'd0) begin
              push_data.event_res = EV_MSG_BYTE;
              push_data.empty_res = 1'b1;
              push                = (cmd_r == CMD_MESSAGE);
            end else begin
              rem_nxt    = pay_len[COUNT_WIDTH-1:0];
              acc_nxt    = 32'd0;
              is_msg_nxt = (cmd_r == CMD_MESSAGE);
              is_hb4_nxt = (cmd_r == CMD_HEARTBEAT) && (pkt_len_r == HB_PKT_LEN);
              phase_nxt  = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_r - COUNT_WIDTH'(1);
          if (rem_last) begin
            phase_nxt = PH_HEADER;
          end
          push_data.last = rem_last;
          if (is_msg_r) begin
            push_data.event_res = EV_MSG_BYTE;
            push_data.data      = {24'd0, data_byte};
            push                = 1'b1;
          end else if (is_hb4_r) begin
            acc_nxt             = {acc_r[23:0], data_byte};
            push_data.event_res = EV_AUDIENCE;
            push_data.data      = acc_nxt;
            push                = rem_last;
          end
        end
        default: begin
          // drop until a new stream starts
        end
      endcase
      push_data.sequence_res = seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= 4'd0;
      limit_r   <= LIMIT_RESET;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    pkt_len_r <= pkt_len_nxt;
    hdr_len_r <= hdr_len_nxt;
    cmd_r     <= cmd_nxt;
    seq_r     <= seq_nxt;
    rem_r     <= rem_nxt;
    acc_r     <= acc_nxt;
    is_msg_r  <= is_msg_nxt;
    is_hb4_r  <= is_hb4_nxt;
  end

endmodule

// ----- src/ppd_queue.sv -----
module ppd_queue import ppd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ppd_result_t push_data,
  output logic        full,
  output logic        pop_valid,
  input  logic        pop,
  output ppd_result_t pop_data
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ppd_result_t         mem [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full      = (cnt_r == CntW'(QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CntW'(1);
      2'b01:   cnt_nxt = cnt_r - CntW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/ppd_back.sv -----
module ppd_back import ppd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  ppd_result_t q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  logic        out_valid_r, out_valid_nxt;
  ppd_result_t res_r;

  // load a new transaction when the output register is empty or being taken
  assign q_pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop) begin
      res_r <= q_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r.sequence_res, res_r.error_code, res_r.data};
  assign out_tuser  = {res_r.empty_res, res_r.event_res};
  assign out_tlast  = res_r.last;

endmodule

// ----- src/push_packet_deframer_unit.sv -----
// Channel   Dir  Fields (tdata / tuser, lowest bit first)          Handshake
// in_       in   tdata: data_byte[7:0]; tuser: start_of_stream       tvalid/tready
// out_      out  tdata: data[31:0], error_code, sequence_res;        tvalid/tready
//                tuser: event_res[1:0], empty_res; tlast: last
// cfg_      in   wr_data: max_payload_length[23:0]                   wr_en
//
// One byte per clock while in_tready is high. Each result is written to the queue at the edge
// that takes its byte, then loaded into the output register that drives out_tvalid.
// The result queue holds QUEUE_DEPTH results behind the output register, so in_tready
// drops only when the queue is full, which takes out_tready held low.
// rst_n is synchronous and active low; it empties the queue and restores the limit.
module push_packet_deframer_unit import ppd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_WIDTH-1:0] cfg_wr_data,  // max_payload_length
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,     // data_byte
  input  logic                   in_tuser,     // start_of_stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [71:0]            out_tdata,    // data[31:0], error_code[33:32],
                                               // sequence_res[65:34], zero fill
  output logic [2:0]             out_tuser,    // event_res[1:0], empty_res[2]
  output logic                   out_tlast     // last
);

  logic        accept;
  logic        push;
  ppd_result_t push_data;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  ppd_result_t q_data;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  ppd_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .accept         (accept),
    .data_byte      (in_tdata),
    .start_of_stream(in_tuser),
    .push           (push),
    .push_data      (push_data)
  );

  ppd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_data (q_data)
  );

  ppd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- dv/ppd_result_checker.sv -----
`timescale 1ns / 1ps

module ppd_result_checker import ppd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [LIMIT_WIDTH-1:0] cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [71:0]            out_tdata,
  input  logic [2:0]             out_tuser,
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     pending_count
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROP    = 2'd2
  } parse_phase_t;

  localparam logic [32:0] COUNT_CAP = (33'd1 << COUNT_WIDTH) - 33'd1;

  ppd_result_t pending_results[$];

  logic [LIMIT_WIDTH-1:0] payload_limit;
  parse_phase_t           phase;
  logic [3:0]             hdr_count;
  logic [31:0]            pkt_len_field;
  logic [15:0]            hdr_len_field;
  logic [31:0]            cmd_field;
  logic [31:0]            seq_field;
  logic [31:0]            bytes_left;
  logic [31:0]            audience_acc;
  int                     mismatches;

  assign mismatch_count = mismatches;

  function automatic void queue_result(input logic [1:0] ev, input logic [31:0] data,
                                       input logic [1:0] code, input logic last,
                                       input logic empty);
    ppd_result_t r;
    r.event_res    = ev;
    r.data         = data;
    r.error_code   = code;
    r.sequence_res = seq_field;
    r.last         = last;
    r.empty_res    = empty;
    pending_results.push_back(r);
  endfunction

  // Parse one accepted byte and queue whatever result it causes.
  function automatic void advance_parser(input logic [7:0] b, input logic sos);
    logic [1:0]  code;
    logic [32:0] len;
    logic        last;
    if (sos) begin
      phase     = PH_HEADER;
      hdr_count = '0;
    end
    case (phase)
      PH_HEADER: begin
        if (hdr_count < 4'd4) pkt_len_field = {pkt_len_field[23:0], b};
        else if (hdr_count < 4'd6) hdr_len_field = {hdr_len_field[7:0], b};
        else if (hdr_count >= 4'd8 && hdr_count < 4'd12) cmd_field = {cmd_field[23:0], b};
        else if (hdr_count >= 4'd12) seq_field = {seq_field[23:0], b};

        if (hdr_count != HDR_LAST_IDX) begin
          hdr_count = hdr_count + 4'd1;
        end else begin
          hdr_count = '0;
          code      = ERR_NONE;
          if (hdr_len_field != HDR_BYTES) begin
            code = ERR_HDR_LEN;
          end else if (cmd_field != CMD_HEARTBEAT && cmd_field != CMD_MESSAGE &&
                       cmd_field != CMD_AUTH) begin
            code = ERR_CMD;
          end else if (pkt_len_field < 32'(hdr_len_field)) begin
            code = ERR_LENGTH;
          end else begin
            len = 33'(pkt_len_field) - 33'(hdr_len_field);
            if (len > 33'(payload_limit) || len > COUNT_CAP) code = ERR_LENGTH;
          end

          if (code != ERR_NONE) begin
            phase = PH_DROP;
            queue_result(EV_ERROR, 32'd0, code, 1'b1, 1'b0);
          end else begin
            len = 33'(pkt_len_field) - 33'(HDR_BYTES);
            if (len == 33'd0) begin
              if (cmd_field == CMD_MESSAGE)
                queue_result(EV_MSG_BYTE, 32'd0, ERR_NONE, 1'b1, 1'b1);
            end else begin
              bytes_left   = len[31:0] & COUNT_CAP[31:0];
              audience_acc = '0;
              phase        = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_left = (bytes_left - 32'd1) & COUNT_CAP[31:0];
        last       = (bytes_left == 32'd0);
        if (last) phase = PH_HEADER;
        if (cmd_field == CMD_MESSAGE) begin
          queue_result(EV_MSG_BYTE, {24'd0, b}, ERR_NONE, last, 1'b0);
        end else if (cmd_field == CMD_HEARTBEAT && pkt_len_field == HB_PKT_LEN) begin
          audience_acc = {audience_acc[23:0], b};
          if (last) queue_result(EV_AUDIENCE, audience_acc, ERR_NONE, 1'b1, 1'b0);
        end
      end
      default: ; // drop until the next start of stream
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    ppd_result_t exp_r;
    if (!rst_n) begin
      pending_results.delete();
      payload_limit = LIMIT_RESET;
      phase         = PH_HEADER;
      hdr_count     = '0;
      pkt_len_field = '0;
      hdr_len_field = '0;
      cmd_field     = '0;
      seq_field     = '0;
      bytes_left    = '0;
      audience_acc  = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0h data %0h",
                   $time, out_tuser[1:0], out_tdata[31:0]);
          mismatches++;
        end else begin
          exp_r = pending_results.pop_front();
          compare_field("event_res", 32'(exp_r.event_res), 32'(out_tuser[1:0]));
          compare_field("data", exp_r.data, out_tdata[31:0]);
          compare_field("error_code", 32'(exp_r.error_code), 32'(out_tdata[33:32]));
          compare_field("sequence_res", exp_r.sequence_res, out_tdata[65:34]);
          compare_field("last", 32'(exp_r.last), 32'(out_tlast));
          compare_field("empty_res", 32'(exp_r.empty_res), 32'(out_tuser[2]));
        end
      end
      if (cfg_wr_en) payload_limit = cfg_wr_data;
      if (in_tvalid && in_tready) advance_parser(in_tdata, in_tuser);
    end
    pending_count <= pending_results.size();
  end

  initial begin
    mismatches    = 0;
    pending_count = 0;
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ppd_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam logic [31:0] HDR            = 32'(HDR_BYTES);

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [LIMIT_WIDTH-1:0] cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [71:0]            out_tdata;
  logic [2:0]             out_tuser;
  logic                   out_tlast;

  int                     mismatch_count;
  int                     pending_count;

  logic                   no_idle      = 1'b0;
  logic                   hold_off_req = 1'b0;
  logic                   need_sos     = 1'b1;
  logic [LIMIT_WIDTH-1:0] limit_now    = LIMIT_RESET;
  int unsigned            items_sent   = 0;

  push_packet_deframer_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  ppd_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void append_be(ref bytes_t q, input logic [31:0] v, input int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) q.push_back(v[8*k +: 8]);
  endfunction

  function automatic bytes_t random_bytes(input int unsigned n);
    bytes_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic bytes_t be_word(input logic [31:0] v);
    bytes_t q;
    append_be(q, v, 4);
    return q;
  endfunction

  function automatic logic [31:0] any_good_cmd();
    case ($urandom_range(2))
      0:       return CMD_HEARTBEAT;
      1:       return CMD_MESSAGE;
      default: return CMD_AUTH;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sos);
    if (!no_idle) begin
      while ($urandom_range(99) < 10) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= sos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send header plus payload; a non-negative cut truncates the frame to that many bytes.
  task automatic send_packet(input logic [31:0] pkt_len, input logic [15:0] hdr_len,
                             input logic [31:0] cmd, input logic [31:0] seq,
                             input bytes_t payload, input int cut);
    bytes_t frame;
    logic   sos;
    append_be(frame, pkt_len, 4);
    append_be(frame, 32'(hdr_len), 2);
    append_be(frame, $urandom, 2);
    append_be(frame, cmd, 4);
    append_be(frame, seq, 4);
    foreach (payload[i]) frame.push_back(payload[i]);
    if (cut >= 0) while (frame.size() > cut) frame.pop_back();
    sos = need_sos || ($urandom_range(7) == 0);
    foreach (frame[i]) begin
      send_byte(frame[i], sos);
      sos = 1'b0;
    end
    // A bad header leaves the parser dropping until the next start of stream.
    need_sos = (cut >= 0) || (hdr_len != HDR_BYTES) ||
               (cmd != CMD_HEARTBEAT && cmd != CMD_MESSAGE && cmd != CMD_AUTH) ||
               (pkt_len < HDR) || (pkt_len - HDR > 32'(limit_now));
  endtask

  task automatic send_random_packet();
    int unsigned pick;
    int unsigned n;
    logic [31:0] cmd;
    logic [15:0] hl;
    pick = $urandom_range(99);
    if (pick < 55) begin
      n = $urandom_range(12);
      if ($urandom_range(7) == 0) n = $urandom_range(48);
      if (limit_now <= 64 && $urandom_range(9) == 0) n = limit_now + $urandom_range(1);
      else if (n > limit_now && $urandom_range(4) != 0) n = n % (limit_now + 1);
      send_packet(HDR + n, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(n), -1);
    end else if (pick < 68) begin
      send_packet(HB_PKT_LEN, HDR_BYTES, CMD_HEARTBEAT, $urandom, random_bytes(4), -1);
    end else if (pick < 73) begin
      n = $urandom_range(9);
      send_packet(HDR + n, HDR_BYTES, CMD_HEARTBEAT, $urandom, random_bytes(n), -1);
    end else if (pick < 80) begin
      n = $urandom_range(10);
      send_packet(HDR + n, HDR_BYTES, CMD_AUTH, $urandom, random_bytes(n), -1);
    end else if (pick < 84) begin
      hl = 16'($urandom);
      if (hl == HDR_BYTES) hl = hl + 16'd1;
      send_packet($urandom, hl, $urandom, $urandom, random_bytes($urandom_range(4)), -1);
    end else if (pick < 88) begin
      cmd = $urandom_range(1) ? $urandom : $urandom_range(15);
      if (cmd == CMD_HEARTBEAT || cmd == CMD_MESSAGE || cmd == CMD_AUTH) cmd = cmd + 32'd1;
      send_packet($urandom, HDR_BYTES, cmd, $urandom, random_bytes($urandom_range(4)), -1);
    end else if (pick < 92) begin
      if ($urandom_range(1))
        send_packet($urandom_range(15), HDR_BYTES, any_good_cmd(), $urandom,
                    random_bytes($urandom_range(4)), -1);
      else
        send_packet(HDR + 32'(limit_now) + 1 + $urandom_range(3), HDR_BYTES, any_good_cmd(),
                    $urandom, random_bytes($urandom_range(4)), -1);
    end else if (pick < 96) begin
      n = 1 + $urandom_range(20);
      if (n > limit_now) n = limit_now;
      send_packet(HDR + n, HDR_BYTES, any_good_cmd(), $urandom, random_bytes(n),
                  $urandom_range(1, 15 + n));
    end else begin
      repeat ($urandom_range(1, 10)) send_byte(8'($urandom), $urandom_range(7) == 0);
      need_sos = 1'b1;
    end
  endtask

  task automatic random_traffic(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) send_random_packet();
  endtask

  // Drain every expected result, then give the pipeline time to go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [LIMIT_WIDTH-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_now   = v;
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= no_idle || ($urandom_range(99) >= 10);
    end
  end

  // End the run when no transaction moves on either channel for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    bytes_t p;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed cases at the reset limit.
    send_packet(HDR, HDR_BYTES, CMD_MESSAGE, 32'hFFFF_FFFF, p, -1);
    p = {};
    p.push_back(8'hFF);
    send_packet(HDR + 1, HDR_BYTES, CMD_MESSAGE, 32'h0, p, -1);
    p = {};
    append_be(p, 32'h0000_FFA5, 3);
    send_packet(HDR + 3, HDR_BYTES, CMD_MESSAGE, 32'h1234_5678, p, -1);
    send_packet(HB_PKT_LEN, HDR_BYTES, CMD_HEARTBEAT, 32'h1, be_word(32'hFFFF_FFFF), -1);
    send_packet(HB_PKT_LEN, HDR_BYTES, CMD_HEARTBEAT, 32'h2, be_word(32'h0), -1);
    send_packet(HDR, HDR_BYTES, CMD_HEARTBEAT, 32'h3, random_bytes(0), -1);
    send_packet(HDR + 6, HDR_BYTES, CMD_HEARTBEAT, 32'h4, random_bytes(6), -1);
    send_packet(HDR, HDR_BYTES, CMD_AUTH, 32'h5, random_bytes(0), -1);
    send_packet(HDR + 5, HDR_BYTES, CMD_AUTH, 32'h6, random_bytes(5), -1);
    // header length checked before command, command before length
    send_packet(HDR, 16'hFFFF, CMD_MESSAGE, 32'h7, random_bytes(3), -1);
    send_packet(32'h0, 16'd17, 32'h0, 32'h8, random_bytes(2), -1);
    send_packet(HDR, HDR_BYTES, 32'hFFFF_FFFF, 32'h9, random_bytes(2), -1);
    send_packet(32'h0, HDR_BYTES, 32'h0, 32'hA, random_bytes(0), -1);
    send_packet(HDR - 1, HDR_BYTES, CMD_MESSAGE, 32'hB, random_bytes(2), -1);
    send_packet(HDR + 32'(LIMIT_RESET) + 1, HDR_BYTES, CMD_MESSAGE, 32'hC, p, -1);
    send_packet(32'hFFFF_FFFF, HDR_BYTES, CMD_AUTH, 32'hD, p, -1);
    // restart in the header, in a message payload, in a heartbeat count
    send_packet(HDR + 4, HDR_BYTES, CMD_MESSAGE, 32'hE, random_bytes(4), 7);
    send_packet(HDR + 10, HDR_BYTES, CMD_MESSAGE, 32'hF, random_bytes(10), 20);
    send_packet(HB_PKT_LEN, HDR_BYTES, CMD_HEARTBEAT, 32'h10, be_word(32'hDEAD_BEEF), 18);
    send_packet(HB_PKT_LEN, HDR_BYTES, CMD_HEARTBEAT, 32'h11, be_word(32'h0102_0304), -1);

    // Hold the result side off so the queue fills and input backs up.
    hold_off_req = 1'b1;
    send_packet(HDR + 48, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(48), -1);
    random_traffic(10);
    settle();

    set_limit('0);
    send_packet(HDR, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(0), -1);
    send_packet(HDR + 1, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(1), -1);
    send_packet(HDR, HDR_BYTES, CMD_HEARTBEAT, $urandom, random_bytes(0), -1);
    random_traffic(15);
    settle();

    set_limit('1);
    no_idle = 1'b1;
    send_packet(HDR + 32'hFF_FFFF, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(3), 19);
    send_packet(HDR + 32'h100_0000, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(2), -1);
    random_traffic(20);
    settle();
    no_idle = 1'b0;

    set_limit(24'd20);
    send_packet(HDR + 20, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(20), -1);
    send_packet(HDR + 21, HDR_BYTES, CMD_MESSAGE, $urandom, random_bytes(3), -1);
    random_traffic(15);
    settle();

    set_limit(LIMIT_WIDTH'($urandom));
    random_traffic(10);
    settle();

    set_limit(LIMIT_RESET);
    random_traffic(10);
    settle();

    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/ppd_pkg.sv
src/ppd_front.sv
src/ppd_queue.sv
src/ppd_back.sv
src/push_packet_deframer_unit.sv
dv/ppd_result_checker.sv
dv/tb_top.sv
